### design/ssag_pkg.sv
// Shared types and constants for the spiral scan address generator.
package ssag_pkg;

   localparam int unsigned POS_W = 12;
   localparam int unsigned DIM_W = 13;
   localparam int unsigned OFFSET_W = 24;
   localparam int unsigned DEFAULT_MAX_DIM = 4096;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd16;

   typedef enum logic [2:0] {
      HEAD_RIGHT = 3'd0,
      HEAD_DOWN  = 3'd1,
      HEAD_LEFT  = 3'd2,
      HEAD_UP    = 3'd3,
      HEAD_LAST  = 3'd4,
      HEAD_DONE  = 3'd5
   } heading_type;

   typedef enum logic [0:0] {
      REG_IMG_WIDTH  = 1'b0,
      REG_IMG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] ring_inset;
      heading_type      heading;
   } scan_state_type;

endpackage

### design/spiral_scan_address_gen.sv
// Spiral scan address generator: top level with config registers and result pipeline.
// An accepted item is held in the stg_ registers, then in the out_ registers on rsp.
// Throughput: one item per cycle while rsp_tready does not stall the pipeline;
// the position update and the row times width multiply each take one register stage.
// Reset clears the pipeline valids, sets both dimensions to 16 and leaves the
// scan finished at (0,0) until a restart item arrives.
module spiral_scan_address_gen #(
   parameter int unsigned MAX_DIM = ssag_pkg::DEFAULT_MAX_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // restart
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,   // pos_x, pos_y, pixel_offset
   output logic [0:0]                    rsp_tuser,   // scan_done
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [ssag_pkg::DIM_W-1:0]    csr_data
);

   logic [ssag_pkg::DIM_W-1:0] width_ff;
   logic [ssag_pkg::DIM_W-1:0] height_ff;
   logic [ssag_pkg::DIM_W-1:0] eff_width;
   logic [ssag_pkg::DIM_W-1:0] eff_height;

   ssag_pkg::scan_state_type   state_ff;
   ssag_pkg::scan_state_type   state_in;

   logic                          stg_valid_ff;
   logic [ssag_pkg::POS_W-1:0]    stg_col_ff;
   logic [ssag_pkg::POS_W-1:0]    stg_row_ff;
   logic [ssag_pkg::DIM_W-1:0]    stg_width_ff;
   logic                          stg_done_ff;

   logic                          out_valid_ff;
   logic [ssag_pkg::POS_W-1:0]    out_x_ff;
   logic [ssag_pkg::POS_W-1:0]    out_y_ff;
   logic [ssag_pkg::OFFSET_W-1:0] out_offset_ff;
   logic                          out_done_ff;

   logic                          out_advance;
   logic                          req_accept;
   logic [25:0]                   offset_full;

   assign eff_width  = ({19'd0, width_ff} > 32'(MAX_DIM)) ?
                       ssag_pkg::DIM_W'(MAX_DIM) : width_ff;
   assign eff_height = ({19'd0, height_ff} > 32'(MAX_DIM)) ?
                       ssag_pkg::DIM_W'(MAX_DIM) : height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ssag_pkg::DIM_RESET;
         height_ff <= ssag_pkg::DIM_RESET;
      end else if (csr_valid) begin
         case (ssag_pkg::reg_index_type'(csr_index))
            ssag_pkg::REG_IMG_WIDTH:  width_ff  <= csr_data;
            ssag_pkg::REG_IMG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_advance = !out_valid_ff || rsp_tready;
   assign req_tready  = !stg_valid_ff || out_advance;
   assign req_accept  = req_tvalid && req_tready;

   ssag_step u_step (
      .state_cur  (state_ff),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .restart    (req_tdata[0]),
      .state_nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.col        <= '0;
         state_ff.row        <= '0;
         state_ff.ring_inset <= '0;
         state_ff.heading    <= ssag_pkg::HEAD_DONE;
         stg_valid_ff        <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_tready) begin
            stg_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_col_ff   <= state_in.col;
         stg_row_ff   <= state_in.row;
         stg_width_ff <= eff_width;
         stg_done_ff  <= (state_in.heading == ssag_pkg::HEAD_DONE);
      end
   end

   assign offset_full = {14'd0, stg_row_ff} * {13'd0, stg_width_ff} + {14'd0, stg_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && stg_valid_ff) begin
         out_x_ff      <= stg_col_ff;
         out_y_ff      <= stg_row_ff;
         out_offset_ff <= offset_full[ssag_pkg::OFFSET_W-1:0];
         out_done_ff   <= stg_done_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_offset_ff, out_y_ff, out_x_ff};
   assign rsp_tuser[0] = out_done_ff;

endmodule

### design/ssag_step.sv
// Next scan position and heading for one restart or advance item.
module ssag_step (
   input  ssag_pkg::scan_state_type       state_cur,
   input  logic [ssag_pkg::DIM_W-1:0]     eff_width,
   input  logic [ssag_pkg::DIM_W-1:0]     eff_height,
   input  logic                           restart,
   output ssag_pkg::scan_state_type       state_nxt
);

   logic signed [14:0] x_s;
   logic signed [14:0] y_s;
   logic signed [14:0] in_s;
   logic signed [14:0] lim_x;
   logic signed [14:0] lim_y;
   logic signed [14:0] x_inc;
   logic signed [14:0] x_dec;
   logic signed [14:0] y_inc;
   logic signed [14:0] y_dec;

   assign x_s   = $signed({3'b000, state_cur.col});
   assign y_s   = $signed({3'b000, state_cur.row});
   assign in_s  = $signed({3'b000, state_cur.ring_inset});
   assign lim_x = $signed({2'b00, eff_width}) - 15'sd1 - in_s;
   assign lim_y = $signed({2'b00, eff_height}) - 15'sd1 - in_s;
   assign x_inc = x_s + 15'sd1;
   assign x_dec = x_s - 15'sd1;
   assign y_inc = y_s + 15'sd1;
   assign y_dec = y_s - 15'sd1;

   always_comb begin
      state_nxt = state_cur;
      if (restart) begin
         state_nxt.col = '0;
         state_nxt.row = '0;
         state_nxt.ring_inset = '0;
         if (eff_width == '0 || eff_height == '0) begin
            state_nxt.heading = ssag_pkg::HEAD_DONE;
         end else if (eff_width == ssag_pkg::DIM_W'(1)) begin
            state_nxt.heading = (eff_height == ssag_pkg::DIM_W'(1)) ?
                                ssag_pkg::HEAD_LAST : ssag_pkg::HEAD_DOWN;
         end else begin
            state_nxt.heading = ssag_pkg::HEAD_RIGHT;
         end
      end else begin
         case (state_cur.heading)
            ssag_pkg::HEAD_RIGHT: begin
               if (x_s < lim_x) begin
                  state_nxt.col = x_inc[ssag_pkg::POS_W-1:0];
                  if (x_inc >= lim_x) begin
                     state_nxt.heading = ssag_pkg::HEAD_DOWN;
                  end
               end else begin
                  state_nxt.heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_DOWN: begin
               if (y_s < lim_y) begin
                  state_nxt.row = y_inc[ssag_pkg::POS_W-1:0];
                  if (y_inc >= lim_y) begin
                     state_nxt.heading = ssag_pkg::HEAD_LEFT;
                  end
               end else begin
                  state_nxt.heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_LEFT: begin
               if (x_s > in_s) begin
                  state_nxt.col = x_dec[ssag_pkg::POS_W-1:0];
                  if (x_dec <= in_s) begin
                     state_nxt.ring_inset = state_cur.ring_inset + 1'b1;
                     state_nxt.heading = ssag_pkg::HEAD_UP;
                  end
               end else begin
                  state_nxt.heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_UP: begin
               if (y_s > in_s) begin
                  state_nxt.row = y_dec[ssag_pkg::POS_W-1:0];
                  if (y_dec <= in_s) begin
                     state_nxt.heading = ssag_pkg::HEAD_RIGHT;
                  end
               end else begin
                  state_nxt.heading = ssag_pkg::HEAD_DONE;
               end
            end
            default: begin
               state_nxt.heading = ssag_pkg::HEAD_DONE;
            end
         endcase
      end
   end

endmodule

### bench/ssag_scan_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts every spiral scan address and compares it with the block's results.
module ssag_scan_checker #(
   parameter int unsigned MAX_DIM = ssag_pkg::DEFAULT_MAX_DIM
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [47:0]                rsp_tdata,
   input  logic [0:0]                 rsp_tuser,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [0:0]                 csr_index,
   input  logic [ssag_pkg::DIM_W-1:0] csr_data,
   output int unsigned                mismatches,
   output int unsigned                pending,
   output int unsigned                results_checked,
   output int unsigned                done_results
);

   localparam int unsigned PRINT_CAP = 40;

   typedef struct packed {
      logic [ssag_pkg::POS_W-1:0]    pos_x;
      logic [ssag_pkg::POS_W-1:0]    pos_y;
      logic [ssag_pkg::OFFSET_W-1:0] offset;
      logic                          done;
   } scan_point_type;

   logic [ssag_pkg::DIM_W-1:0] width_reg = ssag_pkg::DIM_RESET;
   logic [ssag_pkg::DIM_W-1:0] height_reg = ssag_pkg::DIM_RESET;
   logic [ssag_pkg::POS_W-1:0] cur_col = '0;
   logic [ssag_pkg::POS_W-1:0] cur_row = '0;
   logic [ssag_pkg::POS_W-1:0] cur_inset = '0;
   ssag_pkg::heading_type      cur_heading = ssag_pkg::HEAD_DONE;
   scan_point_type             expected_points[$];
   int unsigned                fail_count = 0;
   int unsigned                checked_count = 0;
   int unsigned                done_count = 0;

   function automatic int clamp_dim(input logic [ssag_pkg::DIM_W-1:0] reg_value);
      return (reg_value > MAX_DIM) ? int'(MAX_DIM) : int'(reg_value);
   endfunction

   task automatic report(input string what, input longint unsigned want,
                         input longint unsigned got);
      if (fail_count < PRINT_CAP) begin
         $display("mismatch at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
      end
      fail_count++;
   endtask

   task automatic advance_spiral(input logic restart_bit);
      int              w;
      int              h;
      int              x;
      int              y;
      int              ins;
      longint unsigned linear;
      scan_point_type  point;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      x = int'(cur_col);
      y = int'(cur_row);
      ins = int'(cur_inset);
      if (restart_bit) begin
         x = 0;
         y = 0;
         ins = 0;
         if (w == 0 || h == 0) begin
            cur_heading = ssag_pkg::HEAD_DONE;
         end else if (w == 1) begin
            cur_heading = (h == 1) ? ssag_pkg::HEAD_LAST : ssag_pkg::HEAD_DOWN;
         end else begin
            cur_heading = ssag_pkg::HEAD_RIGHT;
         end
      end else begin
         case (cur_heading)
            ssag_pkg::HEAD_RIGHT: begin
               if (x < w - 1 - ins) begin
                  x++;
                  if (x >= w - 1 - ins) cur_heading = ssag_pkg::HEAD_DOWN;
               end else begin
                  cur_heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_DOWN: begin
               if (y < h - 1 - ins) begin
                  y++;
                  if (y >= h - 1 - ins) cur_heading = ssag_pkg::HEAD_LEFT;
               end else begin
                  cur_heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_LEFT: begin
               if (x > ins) begin
                  x--;
                  if (x <= ins) begin
                     ins++;
                     cur_heading = ssag_pkg::HEAD_UP;
                  end
               end else begin
                  cur_heading = ssag_pkg::HEAD_DONE;
               end
            end
            ssag_pkg::HEAD_UP: begin
               if (y > ins) begin
                  y--;
                  if (y <= ins) cur_heading = ssag_pkg::HEAD_RIGHT;
               end else begin
                  cur_heading = ssag_pkg::HEAD_DONE;
               end
            end
            default: begin
               cur_heading = ssag_pkg::HEAD_DONE;
            end
         endcase
      end
      cur_col = x[ssag_pkg::POS_W-1:0];
      cur_row = y[ssag_pkg::POS_W-1:0];
      cur_inset = ins[ssag_pkg::POS_W-1:0];
      linear = longint'(cur_row) * longint'(w) + longint'(cur_col);
      point.pos_x = cur_col;
      point.pos_y = cur_row;
      point.offset = linear[ssag_pkg::OFFSET_W-1:0];
      point.done = (cur_heading == ssag_pkg::HEAD_DONE);
      expected_points.push_back(point);
   endtask

   always @(posedge clock) begin
      scan_point_type got;
      scan_point_type want;
      if (reset) begin
         width_reg = ssag_pkg::DIM_RESET;
         height_reg = ssag_pkg::DIM_RESET;
         cur_col = '0;
         cur_row = '0;
         cur_inset = '0;
         cur_heading = ssag_pkg::HEAD_DONE;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ssag_pkg::REG_IMG_WIDTH) begin
               width_reg = csr_data;
            end else begin
               height_reg = csr_data;
            end
         end
         if (req_tvalid && req_tready) advance_spiral(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x = rsp_tdata[ssag_pkg::POS_W-1:0];
            got.pos_y = rsp_tdata[2*ssag_pkg::POS_W-1:ssag_pkg::POS_W];
            got.offset = rsp_tdata[2*ssag_pkg::POS_W+ssag_pkg::OFFSET_W-1:2*ssag_pkg::POS_W];
            got.done = rsp_tuser[0];
            if (expected_points.size() == 0) begin
               report("result with nothing outstanding, tdata", 0, rsp_tdata);
            end else begin
               want = expected_points.pop_front();
               if (got.pos_x !== want.pos_x) report("pos_x", want.pos_x, got.pos_x);
               if (got.pos_y !== want.pos_y) report("pos_y", want.pos_y, got.pos_y);
               if (got.offset !== want.offset) report("pixel_offset", want.offset, got.offset);
               if (got.done !== want.done) report("scan_done", want.done, got.done);
               checked_count++;
               if (want.done) done_count++;
            end
         end
      end
      mismatches <= fail_count;
      pending <= expected_points.size();
      results_checked <= checked_count;
      done_results <= done_count;
   end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench top for the spiral scan address generator: stimulus, flow control and verdict.
module tb;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [47:0]                rsp_tdata;
   logic [0:0]                 rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [0:0]                 csr_index = '0;
   logic [ssag_pkg::DIM_W-1:0] csr_data = '0;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned done_results;
   int unsigned items_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;
   int unsigned ready_mode = 0;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;

   spiral_scan_address_gen DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ssag_scan_checker scan_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked),
      .done_results    (done_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without finishing.", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // The receiver switches between always ready, random ready and long stall runs.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(2, 0);
         mode_left <= $urandom_range(300, 40);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else begin
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(99, 0) < 65);
            default: begin
               rsp_tready <= ~rsp_tready;
               hold_left <= rsp_tready ? $urandom_range(12, 1) : $urandom_range(6, 0);
            end
         endcase
      end
   end

   task automatic send_item(input logic restart_bit);
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, restart_bit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic pace();
      int unsigned gap_len;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(24, 1);
         if (gaps_on) begin
            gap_len = $urandom_range(6, 1);
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
   endtask

   task automatic write_reg(input ssag_pkg::reg_index_type idx,
                            input logic [ssag_pkg::DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Waits for the pipeline to drain before touching the image size.
   task automatic write_dims(input logic [ssag_pkg::DIM_W-1:0] w,
                             input logic [ssag_pkg::DIM_W-1:0] h);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(ssag_pkg::REG_IMG_WIDTH, w);
      write_reg(ssag_pkg::REG_IMG_HEIGHT, h);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int unsigned                random_items;
      int unsigned                sel;
      int unsigned                steps;
      logic [ssag_pkg::DIM_W-1:0] w;
      logic [ssag_pkg::DIM_W-1:0] h;
      random_items = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Advances before any restart must report a finished scan at the origin.
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      write_dims(1, 1);
      send_item(1'b1);
      repeat (2) send_item(1'b0);
      write_dims(1, 0);
      send_item(1'b1);
      send_item(1'b0);
      write_dims(0, 5);
      send_item(1'b1);
      send_item(1'b0);
      write_dims(1, 3);
      send_item(1'b1);
      repeat (3) send_item(1'b0);
      write_dims(8191, 2);
      send_item(1'b1);
      repeat (2) send_item(1'b0);
      // The size changes while a scan is in progress.
      write_dims(5, 2);
      repeat (2) send_item(1'b0);

      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(19, 0);
         if (sel == 0) begin
            w = ($urandom_range(1, 0) != 0) ? 13'd8191 :
                ssag_pkg::DIM_W'($urandom_range(8191, 4095));
            h = ssag_pkg::DIM_W'($urandom_range(3, 1));
            steps = $urandom_range(150, 30);
         end else if (sel == 1) begin
            w = ssag_pkg::DIM_W'($urandom_range(3, 1));
            h = ($urandom_range(1, 0) != 0) ? 13'd4096 :
                ssag_pkg::DIM_W'($urandom_range(8191, 4095));
            steps = $urandom_range(150, 30);
         end else if (sel == 2) begin
            if ($urandom_range(1, 0) != 0) begin
               w = '0;
               h = ssag_pkg::DIM_W'($urandom_range(8191, 0));
            end else begin
               w = ssag_pkg::DIM_W'($urandom_range(8191, 0));
               h = '0;
            end
            steps = 3;
         end else begin
            w = ssag_pkg::DIM_W'($urandom_range(12, 1));
            h = ssag_pkg::DIM_W'($urandom_range(12, 1));
            steps = w * h + $urandom_range(4, 0);
         end
         write_dims(w, h);
         gaps_on = ($urandom_range(3, 0) != 0);
         if ($urandom_range(9, 0) != 0) begin
            send_item(1'b1);
            pace();
            random_items++;
         end
         repeat (steps) begin
            send_item($urandom_range(59, 0) == 0);
            pace();
            random_items++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d restart and advance items across %0d image size settings.",
               items_sent, settings_used);
      $display("Checked %0d scan addresses, %0d of them reporting a finished scan.",
               results_checked, done_results);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
design/ssag_pkg.sv
design/ssag_step.sv
design/spiral_scan_address_gen.sv
bench/ssag_scan_checker.sv
bench/tb.sv
